// ===== src/wsp_pkg.sv =====
package wsp_pkg;

    // line framing
    localparam int unsigned LINE_FIELDS = 6;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [7:0]  CHAR_POINT  = 8'h2E;
    localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
    localparam logic [7:0]  CHAR_PLUS   = 8'h2B;
    localparam logic [7:0]  CHAR_M      = 8'h4D;
    localparam logic [7:0]  CHAR_K      = 8'h4B;

    // field positions within a line
    localparam logic [2:0] FLD_ID     = 3'd0;
    localparam logic [2:0] FLD_DIR    = 3'd1;
    localparam logic [2:0] FLD_SPEED  = 3'd2;
    localparam logic [2:0] FLD_UNIT   = 3'd3;
    localparam logic [2:0] FLD_STATUS = 3'd4;
    localparam logic [2:0] FLD_LAST   = 3'(LINE_FIELDS - 1);
    localparam logic [2:0] CNT_MAX    = 3'd7;

    // speed arithmetic
    localparam int unsigned ACC_W      = 27;
    localparam logic [ACC_W-1:0] ACC_CAP = {ACC_W{1'b1}};
    localparam logic [16:0] SPEED_CAP  = 17'd99999;
    // km/h accumulators at or above this give a capped m/s speed
    localparam logic [ACC_W-1:0] KMH_LIMIT = 27'd360000;
    // 5/18 as a fixed-point reciprocal, exact for inputs below the limit
    localparam logic [24:0] KMH_RECIP  = 25'd18641355;
    localparam int unsigned KMH_SHIFT  = 26;
    localparam logic [10:0] HEADING_BASE = 11'd135;

    // what a finished line hands to the output side
    typedef struct packed {
        logic [7:0]       id_char;
        logic [9:0]       dir_accum;
        logic             valid;
        logic             unit_k;
        logic [ACC_W-1:0] speed_accum;
        logic             status_seen;
        logic [7:0]       status_accum;
    } t_line_summary;

endpackage

// ===== src/wsp_byte_if.sv =====
interface wsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/wsp_reading_if.sv =====
interface wsp_reading_if;
    logic               valid;
    logic               ready;
    logic [7:0]         sensor_id;
    logic [9:0]         direction_deg;
    logic signed [10:0] heading_deg;
    logic [16:0]        speed_centi_mps;
    logic               reading_valid;
    logic               units_kmh;
    logic signed [8:0]  status_code;

    modport source (
        output valid, output sensor_id, output direction_deg, output heading_deg,
        output speed_centi_mps, output reading_valid, output units_kmh,
        output status_code, input ready
    );
    modport sink (
        input valid, input sensor_id, input direction_deg, input heading_deg,
        input speed_centi_mps, input reading_valid, input units_kmh,
        input status_code, output ready
    );
endinterface

// ===== src/wsp_line_parser.sv =====
module wsp_line_parser
    import wsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_good,
    output t_line_summary o_summary
);

    typedef struct packed {
        logic [2:0]       field_index;
        logic [2:0]       field_length;
        logic [7:0]       id_char;
        logic [9:0]       dir_accum;
        logic             dir_ok;
        logic [ACC_W-1:0] speed_accum;
        logic [1:0]       frac_digits;
        logic             sp_point;
        logic             sp_minus;
        logic             sp_end;
        logic             speed_long;
        logic [7:0]       unit_char;
        logic [7:0]       status_accum;
        logic             status_seen;
        logic             num_stop;
    } t_line_state;

    t_line_state r_st;
    t_line_state n_st;

    logic        w_is_digit;
    logic [3:0]  w_digit;
    logic [30:0] w_spd_int;
    logic [27:0] w_spd_frac;
    logic [11:0] w_stat;
    logic        w_units_ok;

    // per-character arithmetic
    assign w_is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign w_digit    = i_byte[3:0];
    assign w_spd_int  = 31'(r_st.speed_accum) * 31'd10 + 31'(w_digit) * 31'd100;
    assign w_spd_frac = 28'(r_st.speed_accum) +
                        ((r_st.frac_digits == 2'd0) ? 28'(w_digit) * 28'd10 : 28'(w_digit));
    assign w_stat     = 12'(r_st.status_accum) * 12'd10 + 12'(w_digit);

    // next line state
    always_comb begin
        n_st = r_st;
        if (i_accept) begin
            if (i_byte == CHAR_CR) begin
                n_st = '0;
            end else if (i_byte == CHAR_COMMA) begin
                case (r_st.field_index)
                    FLD_DIR:    n_st.dir_ok = (r_st.field_length >= 3'd3);
                    FLD_SPEED:  n_st.speed_long = (r_st.field_length > 3'd6);
                    FLD_UNIT: begin
                        if (r_st.field_length != 3'd1) n_st.unit_char = '0;
                    end
                    FLD_STATUS: n_st.status_seen = (r_st.field_length != 3'd0);
                    default: ;
                endcase
                if (r_st.field_index != CNT_MAX) n_st.field_index = r_st.field_index + 3'd1;
                n_st.field_length = '0;
                n_st.num_stop     = 1'b0;
            end else begin
                case (r_st.field_index)
                    FLD_ID: begin
                        if (r_st.field_length == 3'd1) n_st.id_char = i_byte;
                    end
                    FLD_DIR: begin
                        if (r_st.field_length < 3'd3 && !r_st.num_stop) begin
                            if (w_is_digit)
                                n_st.dir_accum = r_st.dir_accum * 10'd10 + 10'(w_digit);
                            else
                                n_st.num_stop = 1'b1;
                        end
                    end
                    FLD_SPEED: begin
                        if (!r_st.sp_end) begin
                            if (w_is_digit) begin
                                if (r_st.sp_point) begin
                                    if (r_st.frac_digits != 2'd2) begin
                                        n_st.speed_accum = (w_spd_frac > 28'(ACC_CAP)) ?
                                            ACC_CAP : w_spd_frac[ACC_W-1:0];
                                        n_st.frac_digits = r_st.frac_digits + 2'd1;
                                    end
                                end else begin
                                    n_st.speed_accum = (w_spd_int > 31'(ACC_CAP)) ?
                                        ACC_CAP : w_spd_int[ACC_W-1:0];
                                end
                            end else if (i_byte == CHAR_POINT && !r_st.sp_point) begin
                                n_st.sp_point = 1'b1;
                            end else if ((i_byte == CHAR_MINUS || i_byte == CHAR_PLUS) &&
                                         r_st.field_length == 3'd0) begin
                                if (i_byte == CHAR_MINUS) n_st.sp_minus = 1'b1;
                            end else begin
                                n_st.sp_end = 1'b1;
                            end
                        end
                    end
                    FLD_UNIT: begin
                        if (r_st.field_length == 3'd0) n_st.unit_char = i_byte;
                    end
                    FLD_STATUS: begin
                        if (!r_st.num_stop) begin
                            if (w_is_digit)
                                n_st.status_accum = (w_stat > 12'd255) ? 8'd255 : w_stat[7:0];
                            else
                                n_st.num_stop = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (r_st.field_length != CNT_MAX) n_st.field_length = r_st.field_length + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    // summary of the line as it stands, taken at the carriage return
    assign w_units_ok = (r_st.unit_char == CHAR_M) || (r_st.unit_char == CHAR_K);
    assign o_good     = (r_st.field_index == FLD_LAST);

    always_comb begin
        o_summary.id_char      = r_st.id_char;
        o_summary.dir_accum    = r_st.dir_accum;
        o_summary.valid        = r_st.dir_ok && !r_st.speed_long && !r_st.sp_minus && w_units_ok;
        o_summary.unit_k       = (r_st.unit_char == CHAR_K);
        o_summary.speed_accum  = r_st.speed_accum;
        o_summary.status_seen  = r_st.status_seen;
        o_summary.status_accum = r_st.status_accum;
    end

endmodule

// ===== src/wind_sensor_line_parser.sv =====
// channel    dir  interface        word
// i_rx       in   wsp_byte_if      one received character (rx_byte)
// o_reading  out  wsp_reading_if   one reading per good line
//
// one byte accepted per cycle while i_rx.ready is high; a reading passes through the
// line summary register, then the km/h conversion multiply into the output register
// i_rst_n is synchronous, active low, and clears the line state and both stages
// up to two readings are held, so i_rx.ready drops only when both stages are full
// and the output is stalled; bytes of the next line keep flowing otherwise
module wind_sensor_line_parser
    import wsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsp_byte_if.sink          i_rx,
    wsp_reading_if.source     o_reading
);

    logic          w_in_accept;
    logic          w_good;
    t_line_summary w_summary;
    logic          w_snap_load;
    logic          w_snap_go;

    logic          r_snap_valid;
    t_line_summary r_snap;
    logic          r_out_valid;

    logic [9:0]    w_dir;
    logic [43:0]   w_kmh_prod;
    logic [16:0]   w_speed;

    // character parser
    wsp_line_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_in_accept),
        .i_byte    (i_rx.rx_byte),
        .o_good    (w_good),
        .o_summary (w_summary)
    );

    // handshake
    assign w_snap_go   = r_snap_valid && (!r_out_valid || o_reading.ready);
    assign i_rx.ready  = !r_snap_valid || w_snap_go;
    assign w_in_accept = i_rx.valid && i_rx.ready;
    assign w_snap_load = w_in_accept && (i_rx.rx_byte == CHAR_CR) && w_good;

    // line summary stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_snap_load) begin
            r_snap_valid <= 1'b1;
        end else if (w_snap_go) begin
            r_snap_valid <= 1'b0;
        end
        if (w_snap_load) r_snap <= w_summary;
    end

    // speed conversion and capping
    assign w_dir      = r_snap.valid ? r_snap.dir_accum : '0;
    assign w_kmh_prod = 44'(r_snap.speed_accum[18:0]) * 44'(KMH_RECIP);

    always_comb begin
        if (!r_snap.valid) begin
            w_speed = '0;
        end else if (r_snap.unit_k) begin
            w_speed = (r_snap.speed_accum >= KMH_LIMIT) ? SPEED_CAP :
                      w_kmh_prod[KMH_SHIFT +: 17];
        end else begin
            w_speed = (r_snap.speed_accum > 27'(SPEED_CAP)) ? SPEED_CAP :
                      r_snap.speed_accum[16:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_snap_go) begin
            r_out_valid <= 1'b1;
        end else if (o_reading.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_snap_go) begin
            o_reading.sensor_id       <= r_snap.id_char;
            o_reading.direction_deg   <= w_dir;
            o_reading.heading_deg     <= HEADING_BASE - 11'(w_dir);
            o_reading.speed_centi_mps <= w_speed;
            o_reading.reading_valid   <= r_snap.valid;
            o_reading.units_kmh       <= r_snap.unit_k;
            o_reading.status_code     <= r_snap.status_seen ?
                                         {1'b0, r_snap.status_accum} : '1;
        end
    end

    assign o_reading.valid = r_out_valid;

    // checks
    a_invalid_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reading.valid && !o_reading.reading_valid |->
            o_reading.speed_centi_mps == '0 && o_reading.direction_deg == '0)
        else $error("invalid reading carries nonzero speed or direction");

    a_speed_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_reading.valid |-> o_reading.speed_centi_mps <= SPEED_CAP)
        else $error("speed above cap");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> r_snap_valid && r_out_valid && !o_reading.ready)
        else $error("input stalled with room downstream");

    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_valid && !w_snap_go |=> r_snap_valid && $stable(r_snap))
        else $error("pending line summary lost");

endmodule
